// File: rtl/core/miq_pkg.sv
// Shared types and codes for the middle insert queue.
package miq_pkg;

  localparam int DATA_W = 32;

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

endpackage

// File: rtl/core/miq_ram.sv
// Single-port-write, single-port-read synchronous memory with a registered read.
module miq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  miq_pkg::data_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output miq_pkg::data_t  rdata
);

  miq_pkg::data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/middle_insert_queue.sv
// Top level of the queue with insertion at its middle, built from two memories.
//
// Input channel (in_valid/in_ready): one operation per transfer - append at the
// tail, insert just after the first ceil(n/2) entries, pop the head, or do nothing.
// Output channel (out_valid/out_ready): exactly one result per input transfer,
// carrying the popped value (zero unless a pop succeeded), a status code and
// the occupancy after the operation.
// Each item passes through S_IDLE and S_WB: in the accept cycle both memories are read at
// their half heads and a push is written to the second half store; in the
// following cycle the read data return and a rebalancing move writes the
// first half store. The result register loads at the end of that cycle and
// then offers the result; in_ready is low in S_WB, so no new item is taken
// until the previous one has left S_WB.
// The result register separates the channels: the next input is taken while
// the result is being transferred; while the receiver stalls, at most one
// result waits and in_ready stays low until it is taken.
// Reset clears pointers, counts and handshake state; memory contents stay
// undefined and are never read before written. No clearing pass is needed.
module middle_insert_queue #(
  parameter int CAPACITY = 1024,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_popped_value,
  output logic [1:0]           out_status,
  output logic [CW-1:0]        out_occupancy
);

  typedef enum logic {
    S_IDLE,
    S_WB
  } state_t;

  localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
  localparam logic [CW:0]   CAP_S    = (CW + 1)'(CAPACITY);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_POS : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW + 1)'(p) + (CW + 1)'(c);
    if (s >= CAP_S) begin
      s = s - CAP_S;
    end
    return AW'(s);
  endfunction

  state_t         state_r, state_nxt;
  logic [AW-1:0]  h1_r, h1_nxt, h2_r, h2_nxt;
  logic [CW-1:0]  c1_r, c1_nxt, c2_r, c2_nxt;
  logic           pop_ok_r, pop_ok_nxt;
  logic           reb_r, reb_nxt;
  logic           fwd_r, fwd_nxt;
  miq_pkg::data_t fwd_val_r, fwd_val_nxt;
  miq_pkg::status_t status_r, status_nxt;
  logic           out_valid_r, out_valid_nxt;
  miq_pkg::data_t out_pop_r, out_pop_nxt;
  miq_pkg::status_t out_status_r, out_status_nxt;
  logic [CW-1:0]  out_occ_r, out_occ_nxt;

  logic           accept;
  logic [CW:0]    total;
  logic           full;
  logic           push_ok, pop_ok;
  logic           is_app, is_ins, is_pop;
  logic           s2_we;
  logic [AW-1:0]  s2_waddr;
  logic           s1_we;
  logic [AW-1:0]  s1_waddr;
  miq_pkg::data_t s1_rdata, s2_rdata, moved;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign total   = (CW + 1)'(c1_r) + (CW + 1)'(c2_r);
  assign full    = total >= CAP_S;
  assign is_app  = in_operation == miq_pkg::OP_APPEND;
  assign is_ins  = in_operation == miq_pkg::OP_INSERT;
  assign is_pop  = in_operation == miq_pkg::OP_POP;
  assign push_ok = (is_app || is_ins) && !full;
  assign pop_ok  = is_pop && (c1_r != '0);

  assign s2_we    = accept && push_ok;
  assign s2_waddr = is_ins ? wrap_dec(h2_r) : wrap_add(h2_r, c2_r);

  assign moved    = fwd_r ? fwd_val_r : s2_rdata;
  assign s1_we    = (state_r == S_WB) && reb_r;
  assign s1_waddr = wrap_add(h1_r, c1_r);

  miq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_first_ram (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_waddr),
    .wdata (moved),
    .re    (accept),
    .raddr (h1_r),
    .rdata (s1_rdata)
  );

  miq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_second_ram (
    .clk   (clk),
    .we    (s2_we),
    .waddr (s2_waddr),
    .wdata (miq_pkg::data_t'(in_value)),
    .re    (accept),
    .raddr (h2_r),
    .rdata (s2_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    h1_nxt         = h1_r;
    h2_nxt         = h2_r;
    c1_nxt         = c1_r;
    c2_nxt         = c2_r;
    pop_ok_nxt     = pop_ok_r;
    reb_nxt        = reb_r;
    fwd_nxt        = fwd_r;
    fwd_val_nxt    = fwd_val_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pop_nxt    = out_pop_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pop_ok_nxt  = pop_ok;
          fwd_val_nxt = miq_pkg::data_t'(in_value);
          fwd_nxt     = push_ok && (is_ins || (c2_r == '0));
          if (is_pop) begin
            status_nxt = pop_ok ? miq_pkg::ST_OK : miq_pkg::ST_EMPTY;
          end else if ((is_app || is_ins) && full) begin
            status_nxt = miq_pkg::ST_FULL;
          end else begin
            status_nxt = miq_pkg::ST_OK;
          end
          if (pop_ok) begin
            h1_nxt = wrap_inc(h1_r);
            c1_nxt = c1_r - 1'b1;
          end
          if (push_ok) begin
            c2_nxt = c2_r + 1'b1;
            if (is_ins) begin
              h2_nxt = wrap_dec(h2_r);
            end
          end
          reb_nxt   = c2_nxt > c1_nxt;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (reb_r) begin
          h2_nxt = wrap_inc(h2_r);
          c2_nxt = c2_r - 1'b1;
          c1_nxt = c1_r + 1'b1;
        end
        out_valid_nxt  = 1'b1;
        out_pop_nxt    = pop_ok_r ? s1_rdata : '0;
        out_status_nxt = status_r;
        out_occ_nxt    = CW'((CW + 1)'(c1_r) + (CW + 1)'(c2_r));
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h1_r        <= '0;
      h2_r        <= '0;
      c1_r        <= '0;
      c2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h1_r        <= h1_nxt;
      h2_r        <= h2_nxt;
      c1_r        <= c1_nxt;
      c2_r        <= c2_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pop_ok_r     <= pop_ok_nxt;
    reb_r        <= reb_nxt;
    fwd_r        <= fwd_nxt;
    fwd_val_r    <= fwd_val_nxt;
    status_r     <= status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = signed'(out_pop_r);
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occ_r;

  a_halves_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((c1_r == c2_r) || (c1_r == c2_r + 1'b1)))
    else $error("queue halves out of balance");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= CAP_S)
    else $error("occupancy above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid_r)
    else $error("result missing two cycles after transfer");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == miq_pkg::ST_EMPTY)) |-> (out_pop_r == '0))
    else $error("failed pop carries a value");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the middle insert queue: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP = 1024;
  localparam int AW = $clog2(CAP);
  localparam int CW = $clog2(CAP + 1);
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_DIR = 23;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    miq_pkg::data_t   pop;
    miq_pkg::status_t st;
    logic [CW-1:0]    occ;
  } queue_result_t;

  typedef struct packed {
    miq_pkg::op_t     op;
    miq_pkg::data_t   value;
    bit               fixed;
    miq_pkg::data_t   pop;
    miq_pkg::status_t st;
    logic [CW-1:0]    occ;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_operation = miq_pkg::OP_NONE;
  logic signed [31:0]  in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  out_popped_value;
  logic [1:0]          out_status;
  logic [CW-1:0]       out_occupancy;

  miq_pkg::data_t front_mem [CAP];
  miq_pkg::data_t back_mem [CAP];
  logic [AW-1:0]  front_rd = '0;
  logic [CW-1:0]  front_cnt = '0;
  logic [AW-1:0]  back_rd = '0;
  logic [CW-1:0]  back_cnt = '0;

  queue_result_t  exp_buf [EXP_DEPTH];
  logic [3:0]     exp_wr = '0;
  logic [3:0]     exp_rd = '0;
  dir_row_t       dir_rows [NUM_DIR];
  int             mismatches = 0;
  int             full_hits = 0;
  int             stall_cycles = 0;
  bit             hold_armed = 1'b0;
  bit             hold_done = 1'b0;

  middle_insert_queue #(.CAPACITY(CAP)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  always #1 clk = ~clk;

  task automatic predict_step(input miq_pkg::op_t op, input miq_pkg::data_t val,
                              output queue_result_t res);
    logic [CW:0]    total;
    logic [AW-1:0]  pos;
    miq_pkg::data_t moved;
    res = '{pop: '0, st: miq_pkg::ST_OK, occ: '0};
    total = (CW + 1)'(front_cnt) + (CW + 1)'(back_cnt);
    case (op)
      miq_pkg::OP_APPEND, miq_pkg::OP_INSERT: begin
        if (total >= CAP) begin
          res.st = miq_pkg::ST_FULL;
        end else if (op == miq_pkg::OP_APPEND) begin
          pos = back_rd + back_cnt[AW-1:0];
          back_mem[pos] = val;
          back_cnt++;
        end else begin
          back_rd = back_rd - 1'b1;
          back_mem[back_rd] = val;
          back_cnt++;
        end
      end
      miq_pkg::OP_POP: begin
        if (front_cnt == 0) begin
          res.st = miq_pkg::ST_EMPTY;
        end else begin
          res.pop = front_mem[front_rd];
          front_rd = front_rd + 1'b1;
          front_cnt--;
        end
      end
      default: ;
    endcase
    if (back_cnt > front_cnt) begin
      moved = back_mem[back_rd];
      back_rd = back_rd + 1'b1;
      back_cnt--;
      pos = front_rd + front_cnt[AW-1:0];
      front_mem[pos] = moved;
      front_cnt++;
    end
    res.occ = CW'((CW + 1)'(front_cnt) + (CW + 1)'(back_cnt));
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic miq_pkg::data_t corner_value(input int k);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic pick_item(input int push_pct, output miq_pkg::op_t op,
                           output miq_pkg::data_t v);
    int r;
    r = $urandom_range(99);
    if (r < 3) op = miq_pkg::OP_NONE;
    else if ($urandom_range(99) < push_pct)
      op = $urandom_range(1) ? miq_pkg::OP_INSERT : miq_pkg::OP_APPEND;
    else op = miq_pkg::OP_POP;
    if ($urandom_range(7) == 0) v = corner_value($urandom_range(3));
    else v = $urandom;
  endtask

  // hold valid and payload until the transfer, then predict
  task automatic send_item(input miq_pkg::op_t op, input miq_pkg::data_t val,
                           input bit use_fixed, input queue_result_t fixed);
    queue_result_t res;
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= val;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_step(op, val, res);
    exp_buf[exp_wr] = use_fixed ? fixed : res;
    exp_wr++;
    if (res.st == miq_pkg::ST_FULL) full_hits++;
  endtask

  task automatic idle_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int sender_gap(input int n);
    if ((n / 200) % 3 == 2) return 0;
    return pick_gap();
  endfunction

  initial begin : stimulus
    queue_result_t  fixed;
    miq_pkg::op_t   op;
    miq_pkg::data_t v;
    int             n_sent;
    dir_rows = '{
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, miq_pkg::ST_EMPTY, 11'd0},
      '{miq_pkg::OP_NONE,   32'h7FFF_FFFF, 1'b1, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_APPEND, 32'h8000_0000, 1'b1, 32'h0000_0000, miq_pkg::ST_OK,    11'd1},
      '{miq_pkg::OP_APPEND, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, miq_pkg::ST_OK,    11'd2},
      '{miq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, miq_pkg::ST_OK,    11'd3},
      '{miq_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_APPEND, 32'h0000_0001, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_INSERT, 32'h5555_5555, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_NONE,   32'hAAAA_AAAA, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h1234_5678, 1'b1, 32'h8000_0000, miq_pkg::ST_OK,    11'd5},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, miq_pkg::ST_EMPTY, 11'd0},
      '{miq_pkg::OP_INSERT, 32'h1234_5678, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_INSERT, 32'h8000_0001, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_APPEND, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, miq_pkg::ST_OK,    11'd0},
      '{miq_pkg::OP_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, miq_pkg::ST_EMPTY, 11'd0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NUM_DIR; i++) begin
      fixed = '{pop: dir_rows[i].pop, st: dir_rows[i].st, occ: dir_rows[i].occ};
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].fixed, fixed);
      idle_sender(pick_gap());
    end
    n_sent = 0;
    repeat (300) begin
      pick_item(50, op, v);
      send_item(op, v, 1'b0, fixed);
      idle_sender(sender_gap(n_sent));
      n_sent++;
    end
    // fill to capacity with the receiver held off for a while
    hold_armed = 1'b1;
    full_hits = 0;
    while (full_hits < 20) begin
      pick_item(97, op, v);
      send_item(op, v, 1'b0, fixed);
      idle_sender(sender_gap(n_sent));
      n_sent++;
    end
    // drain for a while
    repeat (350) begin
      pick_item(3, op, v);
      send_item(op, v, 1'b0, fixed);
      idle_sender(sender_gap(n_sent));
      n_sent++;
    end
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("middle_insert_queue verification clean");
    end else begin
      $display("middle_insert_queue verification failed");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        n = HOLD_CYCLES;
      end else if ($urandom_range(99) < 65) begin
        out_ready <= 1'b1;
        n = ($urandom_range(9) == 0) ? $urandom_range(150, 50) : $urandom_range(12, 1);
      end else begin
        out_ready <= 1'b0;
        n = pick_gap() + 1;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(negedge clk) begin : check_results
    queue_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          flag_mismatch("result with nothing pending", out_popped_value, '0);
        end else begin
          want = exp_buf[exp_rd];
          exp_rd++;
          if (out_popped_value !== want.pop)
            flag_mismatch("popped_value", out_popped_value, want.pop);
          if (out_status !== want.st)
            flag_mismatch("status", 32'(out_status), 32'(want.st));
          if (out_occupancy !== want.occ)
            flag_mismatch("occupancy", 32'(out_occupancy), 32'(want.occ));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("middle_insert_queue verification failed");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
rtl/core/miq_pkg.sv
rtl/core/miq_ram.sv
rtl/core/middle_insert_queue.sv
tb/tb_top.sv
